// File: design/qsg_pkg.sv
// Shared types, register map and reset values for the quadrature sweep generator.
`default_nettype none
package qsg_pkg;

    localparam int unsigned REG_COUNT  = 7;
    localparam int unsigned ADDR_WIDTH = 5;
    localparam int unsigned POS_WIDTH  = 17;
    localparam int unsigned CFG_WIDTH  = 16;

    typedef enum logic [2:0] {
        REG_FULL_MAX    = 3'd0,
        REG_FULL_MIN    = 3'd1,
        REG_CENTER      = 3'd2,
        REG_SMALL_MAX   = 3'd3,
        REG_SMALL_MIN   = 3'd4,
        REG_BIG_CROSS   = 3'd5,
        REG_SMALL_CROSS = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic signed [CFG_WIDTH-1:0] full_max_position;
        logic signed [CFG_WIDTH-1:0] full_min_position;
        logic signed [CFG_WIDTH-1:0] center_position;
        logic signed [CFG_WIDTH-1:0] small_max_offset;
        logic signed [CFG_WIDTH-1:0] small_min_offset;
        logic [CFG_WIDTH-1:0]        big_loop_crossings;
        logic [CFG_WIDTH-1:0]        small_loop_crossings;
    } cfg_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] position_count;
        logic                        direction_up;
        logic                        big_loop_active;
        logic [CFG_WIDTH-1:0]        crossings_left;
        logic signed [POS_WIDTH-1:0] upper_bound;
        logic signed [POS_WIDTH-1:0] lower_bound;
        logic [1:0]                  quad_phase;
    } sweep_state_t;

    localparam cfg_t CFG_RESET = '{
        full_max_position:    16'sd1000,
        full_min_position:    -16'sd1000,
        center_position:      16'sd0,
        small_max_offset:     16'sd100,
        small_min_offset:     -16'sd100,
        big_loop_crossings:   16'd2,
        small_loop_crossings: 16'd4
    };

    localparam sweep_state_t STATE_RESET = '{
        position_count:  '0,
        direction_up:    1'b1,
        big_loop_active: 1'b1,
        crossings_left:  '0,
        upper_bound:     '0,
        lower_bound:     '0,
        quad_phase:      2'd0
    };

endpackage
`default_nettype wire

// File: design/qsg_regs.sv
// APB register file holding the sweep limits, center and crossing counts.
`default_nettype none
module qsg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [qsg_pkg::ADDR_WIDTH-1:0]    paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready,
    output qsg_pkg::cfg_t                          cfg
);

    qsg_pkg::cfg_t cfg_reg;
    qsg_pkg::cfg_t cfg_next;
    logic [2:0]    index;
    logic          write_en;

    assign pready   = 1'b1;
    assign index    = paddr[4:2];
    assign write_en = psel && penable && pwrite;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            case (index)
                qsg_pkg::REG_FULL_MAX:    cfg_next.full_max_position    = pwdata[15:0];
                qsg_pkg::REG_FULL_MIN:    cfg_next.full_min_position    = pwdata[15:0];
                qsg_pkg::REG_CENTER:      cfg_next.center_position      = pwdata[15:0];
                qsg_pkg::REG_SMALL_MAX:   cfg_next.small_max_offset     = pwdata[15:0];
                qsg_pkg::REG_SMALL_MIN:   cfg_next.small_min_offset     = pwdata[15:0];
                qsg_pkg::REG_BIG_CROSS:   cfg_next.big_loop_crossings   = pwdata[15:0];
                qsg_pkg::REG_SMALL_CROSS: cfg_next.small_loop_crossings = pwdata[15:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            qsg_pkg::REG_FULL_MAX:    prdata = {16'd0, cfg_reg.full_max_position};
            qsg_pkg::REG_FULL_MIN:    prdata = {16'd0, cfg_reg.full_min_position};
            qsg_pkg::REG_CENTER:      prdata = {16'd0, cfg_reg.center_position};
            qsg_pkg::REG_SMALL_MAX:   prdata = {16'd0, cfg_reg.small_max_offset};
            qsg_pkg::REG_SMALL_MIN:   prdata = {16'd0, cfg_reg.small_min_offset};
            qsg_pkg::REG_BIG_CROSS:   prdata = {16'd0, cfg_reg.big_loop_crossings};
            qsg_pkg::REG_SMALL_CROSS: prdata = {16'd0, cfg_reg.small_loop_crossings};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= qsg_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// File: design/qsg_step.sv
// Next-state logic for one tick: restart, crossing count, bound reload and step.
`default_nettype none
module qsg_step (
    input  wire logic                  restart,
    input  wire qsg_pkg::cfg_t         cfg,
    input  wire qsg_pkg::sweep_state_t cur,
    output qsg_pkg::sweep_state_t      nxt
);

    qsg_pkg::sweep_state_t        pre;
    qsg_pkg::sweep_state_t        loaded;
    logic signed [qsg_pkg::POS_WIDTH-1:0] center_ext;
    logic signed [qsg_pkg::POS_WIDTH-1:0] full_max_ext;
    logic signed [qsg_pkg::POS_WIDTH-1:0] full_min_ext;
    logic signed [qsg_pkg::POS_WIDTH-1:0] small_max;
    logic signed [qsg_pkg::POS_WIDTH-1:0] small_min;

    assign center_ext   = qsg_pkg::POS_WIDTH'(cfg.center_position);
    assign full_max_ext = qsg_pkg::POS_WIDTH'(cfg.full_max_position);
    assign full_min_ext = qsg_pkg::POS_WIDTH'(cfg.full_min_position);
    assign small_max    = center_ext + qsg_pkg::POS_WIDTH'(cfg.small_max_offset);
    assign small_min    = center_ext + qsg_pkg::POS_WIDTH'(cfg.small_min_offset);

    // restart: home the shaft and select the big sweep, keep the direction
    always_comb
    begin
        pre = cur;
        if (restart)
        begin
            pre.position_count  = '0;
            pre.big_loop_active = 1'b1;
            pre.upper_bound     = full_max_ext;
            pre.lower_bound     = full_min_ext;
            pre.crossings_left  = cfg.big_loop_crossings;
        end
    end

    // center visit: count down, or toggle the sweep once the count is spent
    always_comb
    begin
        loaded = pre;
        if (pre.position_count == center_ext)
        begin
            if (pre.crossings_left == '0)
            begin
                if (pre.big_loop_active)
                begin
                    loaded.big_loop_active = 1'b0;
                    loaded.upper_bound     = small_max;
                    loaded.lower_bound     = small_min;
                    loaded.crossings_left  = cfg.small_loop_crossings;
                end
                else
                begin
                    loaded.big_loop_active = 1'b1;
                    loaded.upper_bound     = full_max_ext;
                    loaded.lower_bound     = full_min_ext;
                    loaded.crossings_left  = cfg.big_loop_crossings;
                end
            end
            else
            begin
                loaded.crossings_left = pre.crossings_left - 16'd1;
            end
        end
    end

    // step toward the active bound; reverse in place when it is reached
    always_comb
    begin
        nxt = loaded;
        if (loaded.direction_up)
        begin
            if (loaded.position_count < loaded.upper_bound)
            begin
                nxt.position_count = loaded.position_count + 17'sd1;
                nxt.quad_phase     = loaded.quad_phase + 2'd1;
            end
            else
            begin
                nxt.direction_up = 1'b0;
            end
        end
        else
        begin
            if (loaded.position_count > loaded.lower_bound)
            begin
                nxt.position_count = loaded.position_count - 17'sd1;
                nxt.quad_phase     = loaded.quad_phase - 2'd1;
            end
            else
            begin
                nxt.direction_up = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: design/quadrature_sweep_generator.sv
// Top level of the quadrature sweep generator: state, result register and ports.
//
// Each accepted input transaction is one timer tick and yields exactly one result
// transaction. A tick is accepted in every cycle while the result register is empty or
// its result is being taken in the same cycle, so while out_ready holds high the sustained
// rate is one tick per clock; the result appears in the cycle after acceptance, held in
// the single result register behind the tick logic. Send restart=1 on the first tick to
// load the full limits and crossing count. Configuration writes over APB take effect at the
// next bound or count load; the center check reads the center register directly.
`default_nettype none
module quadrature_sweep_generator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [qsg_pkg::ADDR_WIDTH-1:0]      paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                restart,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     phase_a,
    output logic                                     phase_b,
    output logic signed [qsg_pkg::POS_WIDTH-1:0]     position,
    output logic                                     moving_up,
    output logic                                     in_big_loop
);

    qsg_pkg::cfg_t         cfg;
    qsg_pkg::sweep_state_t state_reg;
    qsg_pkg::sweep_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  accept;

    qsg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qsg_step u_step (
        .restart (restart),
        .cfg     (cfg),
        .cur     (state_reg),
        .nxt     (state_next)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // the state doubles as the result register: it holds until the next tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qsg_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                state_reg <= state_next;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign phase_a     = state_reg.quad_phase[0] ^ state_reg.quad_phase[1];
    assign phase_b     = state_reg.quad_phase[1];
    assign position    = state_reg.position_count;
    assign moving_up   = state_reg.direction_up;
    assign in_big_loop = state_reg.big_loop_active;

endmodule
`default_nettype wire
